/* hw/rtl/assert_macros.svh */
// Assertion helpers; compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

/* hw/rtl/sabc_pkg.sv */
`timescale 1ns / 1ps
package sabc_pkg;

    localparam int POS_W = 24;
    localparam int EXT_W = 14;
    localparam int VEL_W = 16;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic        [EXT_W-1:0] half_w;
        logic        [EXT_W-1:0] half_h;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic                    last_item;
    } in_t;

    typedef struct packed {
        logic                    box_hit;
        logic signed [POS_W-1:0] new_pos_x;
        logic signed [POS_W-1:0] new_pos_y;
        logic                    last_result;
    } out_t;

    // request handed from front to back
    typedef struct packed {
        in_t  item;
        logic closing;
    } cmd_t;

    typedef struct packed {
        logic loading;
        logic walking;
    } bk_stat_t;

    typedef enum logic [2:0] {
        BK_LOAD,
        BK_WALK,
        BK_DRAIN,
        BK_EMIT_RD,
        BK_EMIT_CALC,
        BK_EMIT_OUT
    } bk_state_t;

endpackage

/* hw/rtl/sabc_front.sv */
`timescale 1ns / 1ps
module sabc_front
    import sabc_pkg::*;
#(
    parameter int MAX_BOXES = 64
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic cmd_valid,
    input  logic cmd_ready,
    output cmd_t cmd_data
);
    localparam int CW = $clog2(MAX_BOXES + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          vld_reg, vld_next;
    cmd_t          cmd_reg, cmd_next;
    logic          closing;

    assign s_ready   = !vld_reg || cmd_ready;
    assign cmd_valid = vld_reg;
    assign cmd_data  = cmd_reg;

    // a full set closes itself
    assign closing = s_data.last_item || (cnt_reg == CW'(MAX_BOXES - 1));

    always_comb begin
        cnt_next = cnt_reg;
        vld_next = vld_reg;
        cmd_next = cmd_reg;
        if (cmd_ready) begin
            vld_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            vld_next         = 1'b1;
            cmd_next.item    = s_data;
            cmd_next.closing = closing;
            cnt_next         = closing ? '0 : cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            vld_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            vld_reg <= vld_next;
        end
        cmd_reg <= cmd_next;
    end
endmodule

/* hw/rtl/sabc_queue.sv */
`timescale 1ns / 1ps
module sabc_queue
    import sabc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_data
);
    cmd_t       slot_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] n_reg, n_next;
    logic       do_push, do_pop;

    assign push_ready = (n_reg != 2'd2);
    assign pop_valid  = (n_reg != 2'd0);
    assign pop_data   = slot_reg[rp_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wp_next = wp_reg ^ do_push;
        rp_next = rp_reg ^ do_pop;
        n_next  = n_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            n_reg  <= 2'd0;
        end else begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            n_reg  <= n_next;
        end
        if (do_push) begin
            slot_reg[wp_reg] <= push_data;
        end
    end
endmodule

/* hw/rtl/sabc_back.sv */
`timescale 1ns / 1ps
module sabc_back
    import sabc_pkg::*;
#(
    parameter int MAX_BOXES = 64
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    input  cmd_t     cmd_data,
    output logic     m_valid,
    input  logic     m_ready,
    output out_t     m_data,
    output bk_stat_t stat
);
    localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CW = $clog2(MAX_BOXES + 1);

    typedef struct packed {
        logic               ok;
        logic               bounded;
        logic signed [26:0] nlo;
        logic signed [26:0] nhi;
        logic signed [16:0] den;
    } span_t;

    function automatic span_t mk_span(input logic signed [26:0] a,
                                      input logic signed [26:0] b,
                                      input logic signed [16:0] d);
        span_t s;
        s.ok      = 1'b1;
        s.bounded = 1'b0;
        s.nlo     = a;
        s.nhi     = b;
        s.den     = d;
        if (d == 17'sd0) begin
            s.ok = (a <= 27'sd0) && (b >= 27'sd0);
        end else if (d > 17'sd0) begin
            s.bounded = 1'b1;
        end else begin
            s.bounded = 1'b1;
            s.nlo     = -b;
            s.nhi     = -a;
            s.den     = -d;
        end
        return s;
    endfunction

    function automatic logic signed [24:0] centre(input logic signed [23:0] p,
                                                  input logic [13:0] h);
        return {p[23], p} + {11'd0, h};
    endfunction

    function automatic logic signed [23:0] sat_add(input logic signed [23:0] p,
                                                   input logic signed [15:0] v);
        logic signed [24:0] s;
        s = {p[23], p} + {{9{v[15]}}, v};
        if (s[24] != s[23]) begin
            return s[24] ? {1'b1, 23'd0} : {1'b0, {23{1'b1}}};
        end
        return s[23:0];
    endfunction

    in_t mem [MAX_BOXES];
    in_t rd_a_reg, rd_b_reg;

    bk_state_t     st_reg, st_next;
    logic [CW-1:0] cnt_reg, cnt_next, n_reg, n_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [IW-1:0] addr_a, addr_b;
    logic          issue, wr_en, clr_hits;
    logic [MAX_BOXES-1:0] hit_reg, hit_set;
    out_t          out_reg, out_next;

    // pair pipeline
    logic          v1_reg, v2_reg, v3_reg;
    logic [IW-1:0] i1_reg, j1_reg, i2_reg, j2_reg, i3_reg, j3_reg;
    span_t         sx_reg, sy_reg;
    logic          fail_reg, both_reg;
    logic signed [43:0] p1_reg, p2_reg, p3_reg, p4_reg;

    logic signed [24:0] ox, oy, cx, cy;
    logic        [14:0] ex, ey;
    logic signed [26:0] ax, bx, ay, by;
    logic signed [16:0] dx, dy;
    logic               fail_c, hit_d;

    assign cmd_ready    = (st_reg == BK_LOAD);
    assign m_valid      = (st_reg == BK_EMIT_OUT);
    assign m_data       = out_reg;
    assign stat.loading = (st_reg == BK_LOAD);
    assign stat.walking = (st_reg == BK_WALK);

    assign addr_a = (st_reg == BK_WALK) ? i_reg[IW-1:0] : k_reg[IW-1:0];
    assign addr_b = j_reg[IW-1:0];

    always_comb begin
        st_next  = st_reg;
        cnt_next = cnt_reg;
        n_next   = n_reg;
        i_next   = i_reg;
        j_next   = j_reg;
        k_next   = k_reg;
        out_next = out_reg;
        issue    = 1'b0;
        wr_en    = 1'b0;
        clr_hits = 1'b0;
        case (st_reg)
            BK_LOAD: begin
                if (cmd_valid) begin
                    wr_en    = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (cmd_data.closing) begin
                        n_next   = cnt_reg + 1'b1;
                        clr_hits = 1'b1;
                        i_next   = '0;
                        j_next   = CW'(1);
                        st_next  = (cnt_reg == '0) ? BK_DRAIN : BK_WALK;
                    end
                end
            end
            BK_WALK: begin
                issue = 1'b1;
                if (j_reg + 1'b1 < n_reg) begin
                    j_next = j_reg + 1'b1;
                end else begin
                    i_next = i_reg + 1'b1;
                    j_next = i_reg + CW'(2);
                    if (i_reg + CW'(2) >= n_reg) begin
                        st_next = BK_DRAIN;
                    end
                end
            end
            BK_DRAIN: begin
                if (!v1_reg && !v2_reg && !v3_reg) begin
                    k_next  = '0;
                    st_next = BK_EMIT_RD;
                end
            end
            BK_EMIT_RD: begin
                st_next = BK_EMIT_CALC;
            end
            BK_EMIT_CALC: begin
                out_next.box_hit     = hit_reg[k_reg[IW-1:0]];
                out_next.new_pos_x   = sat_add(rd_a_reg.pos_x, rd_a_reg.vel_x);
                out_next.new_pos_y   = sat_add(rd_a_reg.pos_y, rd_a_reg.vel_y);
                out_next.last_result = (k_reg + 1'b1 == n_reg);
                st_next              = BK_EMIT_OUT;
            end
            BK_EMIT_OUT: begin
                if (m_ready) begin
                    if (k_reg + 1'b1 == n_reg) begin
                        cnt_next = '0;
                        st_next  = BK_LOAD;
                    end else begin
                        k_next  = k_reg + 1'b1;
                        st_next = BK_EMIT_RD;
                    end
                end
            end
            default: st_next = BK_LOAD;
        endcase
    end

    // stage B: grown slab numerators from the two boxes read last cycle
    always_comb begin
        ox = centre(rd_a_reg.pos_x, rd_a_reg.half_w);
        oy = centre(rd_a_reg.pos_y, rd_a_reg.half_h);
        cx = centre(rd_b_reg.pos_x, rd_b_reg.half_w);
        cy = centre(rd_b_reg.pos_y, rd_b_reg.half_h);
        ex = {1'b0, rd_a_reg.half_w} + {1'b0, rd_b_reg.half_w};
        ey = {1'b0, rd_a_reg.half_h} + {1'b0, rd_b_reg.half_h};
        ax = {{2{cx[24]}}, cx} - {12'd0, ex} - {{2{ox[24]}}, ox};
        bx = {{2{cx[24]}}, cx} + {12'd0, ex} - {{2{ox[24]}}, ox};
        ay = {{2{cy[24]}}, cy} - {12'd0, ey} - {{2{oy[24]}}, oy};
        by = {{2{cy[24]}}, cy} + {12'd0, ey} - {{2{oy[24]}}, oy};
        dx = {rd_a_reg.vel_x[15], rd_a_reg.vel_x} - {rd_b_reg.vel_x[15], rd_b_reg.vel_x};
        dy = {rd_a_reg.vel_y[15], rd_a_reg.vel_y} - {rd_b_reg.vel_y[15], rd_b_reg.vel_y};
    end

    // stage C: per-axis range check against [0,1], signed compares
    assign fail_c = !sx_reg.ok || !sy_reg.ok
        || (sx_reg.bounded && ((sx_reg.nlo > $signed({10'd0, sx_reg.den}))
                               || (sx_reg.nhi < 27'sd0)))
        || (sy_reg.bounded && ((sy_reg.nlo > $signed({10'd0, sy_reg.den}))
                               || (sy_reg.nhi < 27'sd0)));

    // stage D: interval overlap by cross products
    assign hit_d = !fail_reg && !(both_reg && ((p1_reg > p2_reg) || (p3_reg > p4_reg)));

    // both boxes of a meeting pair get their flag
    always_comb begin
        hit_set = '0;
        if (v3_reg && hit_d) begin
            hit_set[i3_reg] = 1'b1;
            hit_set[j3_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= BK_LOAD;
            cnt_reg <= '0;
            n_reg   <= '0;
            i_reg   <= '0;
            j_reg   <= '0;
            k_reg   <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            hit_reg <= '0;
        end else begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
            n_reg   <= n_next;
            i_reg   <= i_next;
            j_reg   <= j_next;
            k_reg   <= k_next;
            v1_reg  <= issue;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            if (clr_hits) begin
                hit_reg <= '0;
            end else begin
                hit_reg <= hit_reg | hit_set;
            end
        end
        out_reg <= out_next;
        i1_reg  <= i_reg[IW-1:0];
        j1_reg  <= j_reg[IW-1:0];
        i2_reg  <= i1_reg;
        j2_reg  <= j1_reg;
        i3_reg  <= i2_reg;
        j3_reg  <= j2_reg;
        sx_reg  <= mk_span(ax, bx, dx);
        sy_reg  <= mk_span(ay, by, dy);
        fail_reg <= fail_c;
        both_reg <= sx_reg.bounded && sy_reg.bounded;
        p1_reg  <= 44'(sx_reg.nlo * sy_reg.den);
        p2_reg  <= 44'(sy_reg.nhi * sx_reg.den);
        p3_reg  <= 44'(sy_reg.nlo * sx_reg.den);
        p4_reg  <= 44'(sx_reg.nhi * sy_reg.den);
    end

    // box store: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[cnt_reg[IW-1:0]] <= cmd_data.item;
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end
endmodule

/* hw/rtl/swept_aabb_all_pairs_collision.sv */
`timescale 1ns / 1ps
// Swept box collision over one frame. Boxes stream in one request per cycle
// while s_ready is high and are stored; the request with last_item set (or
// the one that fills MAX_BOXES) closes the set. The block then tests every
// pair i<j, one pair per cycle through a four-stage pipeline (dual-port
// read, slab numerators, cross products, compare), then drains it. Results
// follow in load order, one per box; each passes through memory read,
// saturating add and output register and waits out any stall on m_ready,
// before the next box is read. New requests queue in a two-deep buffer
// behind the front register while the back end walks or emits; the back end
// takes the next request only once the previous frame's results are all out.
`include "assert_macros.svh"
module swept_aabb_all_pairs_collision
    import sabc_pkg::*;
#(
    parameter int MAX_BOXES = 64
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);
    logic     fq_valid, fq_ready, bq_valid, bq_ready;
    cmd_t     fq_data, bq_data;
    bk_stat_t bk_stat;

    sabc_front #(.MAX_BOXES(MAX_BOXES)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (fq_valid),
        .cmd_ready (fq_ready),
        .cmd_data  (fq_data)
    );

    sabc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (bq_valid),
        .pop_ready  (bq_ready),
        .pop_data   (bq_data)
    );

    sabc_back #(.MAX_BOXES(MAX_BOXES)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (bq_valid),
        .cmd_ready (bq_ready),
        .cmd_data  (bq_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .stat      (bk_stat)
    );

    // front holds a request the queue could not take
    `ASSERT_AT(a_front_hold, aclk, aresetn, fq_valid && !fq_ready |=> fq_valid && $stable(fq_data))
    // after the final result the back end goes back to loading
    `ASSERT_AT(a_last_ends, aclk, aresetn, m_valid && m_ready && m_data.last_result |=> bk_stat.loading)
    // no result is shown while boxes load or pairs are walked
    `ASSERT_NEVER(a_no_out_busy, aclk, aresetn, m_valid && (bk_stat.loading || bk_stat.walking))
endmodule
